### rtl/md5_pkg.sv
package md5_pkg;

  // payload of the message channel
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        message_end;
  } md5_in_t;

  // payload of the digest channel
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
  } md5_out_t;

  // classified item passed from the front end to the core
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
  } md5_item_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] MAX_BYTES = 3'd4;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LEN_HIGH   = 6'd60;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word used by round i
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
      2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
      default: idx = 4'(lo * 4'd7);
    endcase
    return idx;
  endfunction

  // rotate amount of round i
  function automatic logic [4:0] rot_of(input logic [5:0] i);
    return ROT_AMT[{i[5:4], i[1:0]}];
  endfunction

  // auxiliary function of each phase
  function automatic logic [31:0] aux_f(input logic [1:0] phase, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] x;
    x = {v, v} << s;
    return x[63:32];
  endfunction

endpackage

### rtl/md5_front.sv
module md5_front
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_ready,
  input  md5_in_t   msg,
  output logic      push_valid,
  input  logic      push_ready,
  output md5_item_t push_item
);

  logic      hold_valid;
  md5_item_t hold;
  logic [2:0] cnt_sat;

  // saturate the byte count to one word
  always_comb begin
    cnt_sat = (msg.byte_count > MAX_BYTES) ? MAX_BYTES : msg.byte_count;
  end

  assign msg_ready  = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_item  = hold;

  // holding stage in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (msg_valid && msg_ready) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_valid && msg_ready) begin
      hold.data <= msg.data_word;
      hold.cnt  <= cnt_sat;
      hold.last <= msg.message_end;
    end
  end

endmodule

### rtl/md5_queue.sv
module md5_queue
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  md5_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output md5_item_t pop_item
);

  md5_item_t                store [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]      wr_ptr;
  logic [QUEUE_AW-1:0]      rd_ptr;
  logic [QUEUE_AW:0]        count;
  logic                     do_push;
  logic                     do_pop;

  assign push_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_item;
    end
  end

endmodule

### rtl/md5_core.sv
module md5_core
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  md5_item_t item,
  output logic      dig_valid,
  input  logic      dig_ready,
  output md5_out_t  dig
);

  typedef enum logic [5:0] {
    ST_ABSORB = 6'b000001,
    ST_PAD    = 6'b000010,
    ST_LEN    = 6'b000100,
    ST_RND    = 6'b001000,
    ST_ADD    = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t      state;
  state_t      ret_state;
  logic [31:0] chain [4];
  logic [31:0] buffer [16];
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic [2:0]  left_cnt;
  logic [31:0] left_data;
  logic        pend_last;
  logic        pad_first;
  logic [5:0]  rnd;
  logic [31:0] ra, rb, rc, rd;
  logic [31:0] wk;
  logic [1:0]  out_idx;

  // byte writer signals
  logic        wr_en;
  logic [31:0] wr_data;
  logic [2:0]  wr_cnt;
  logic        src_last;
  logic        use_left;
  logic [6:0]  room;
  logic [2:0]  n_wr;
  logic [2:0]  n_left;
  logic [31:0] rest_data;
  logic [6:0]  fill_sum;
  logic        full;
  logic [6:0]  wr_pos [4];
  logic [5:0]  pad_gap;
  logic [2:0]  pad_cnt;

  // round datapath
  logic [5:0]  rnd_next;
  logic [31:0] wk_next;
  logic [31:0] t_sum;
  logic [31:0] b_new;

  assign use_left   = (left_cnt != '0);
  assign item_ready = (state == ST_ABSORB) && !use_left;

  // padding byte count up to the length field or the block end
  always_comb begin
    pad_gap = (fill < LEN_OFFSET) ? (LEN_OFFSET - fill) : (6'd0 - fill);
    pad_cnt = (pad_gap >= 6'd4) ? MAX_BYTES : pad_gap[2:0];
  end

  // choose what the byte writer stores this cycle
  always_comb begin
    wr_en    = 1'b0;
    wr_data  = '0;
    wr_cnt   = '0;
    src_last = 1'b0;
    unique case (state) inside
      ST_ABSORB: begin
        if (use_left) begin
          wr_en    = 1'b1;
          wr_data  = left_data;
          wr_cnt   = left_cnt;
          src_last = pend_last;
        end else begin
          wr_en    = item_valid;
          wr_data  = item.data;
          wr_cnt   = item.cnt;
          src_last = item.last;
        end
      end
      ST_PAD: begin
        wr_en   = pad_first || (fill != LEN_OFFSET);
        wr_data = pad_first ? {24'd0, PAD_MARK} : 32'd0;
        wr_cnt  = pad_first ? 3'd1 : pad_cnt;
      end
      ST_LEN: begin
        wr_en   = 1'b1;
        wr_data = (fill == LEN_OFFSET) ? bit_length[31:0] : bit_length[63:32];
        wr_cnt  = MAX_BYTES;
      end
      ST_RND, ST_ADD, ST_OUT: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // split the write at the block end, keep the rest for the next block
  always_comb begin
    room      = 7'd64 - {1'b0, fill};
    n_wr      = ({4'd0, wr_cnt} > room) ? room[2:0] : wr_cnt;
    n_left    = wr_cnt - n_wr;
    rest_data = wr_data >> {n_wr, 3'b000};
    fill_sum  = {1'b0, fill} + {4'd0, n_wr};
    full      = fill_sum[6];
    for (int k = 0; k < 4; k++) begin
      wr_pos[k] = {1'b0, fill} + 7'(k);
    end
  end

  // block buffer, byte writes
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (wr_en && (3'(k) < wr_cnt) && !wr_pos[k][6]) begin
        buffer[wr_pos[k][5:2]][{wr_pos[k][1:0], 3'b000} +: 8] <= wr_data[8*k +: 8];
      end
    end
  end

  // one compression round, message word and constant registered in the cycle before
  always_comb begin
    rnd_next = (state == ST_RND) ? rnd + 6'd1 : 6'd0;
    wk_next  = buffer[msg_index(rnd_next)] + ROUND_K[rnd_next];
    t_sum    = ra + aux_f(rnd[5:4], rb, rc, rd) + wk;
    b_new    = rb + rotl32(t_sum, rot_of(rnd));
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ABSORB;
      ret_state  <= ST_ABSORB;
      chain[0]   <= INIT_A;
      chain[1]   <= INIT_B;
      chain[2]   <= INIT_C;
      chain[3]   <= INIT_D;
      fill       <= '0;
      bit_length <= '0;
      left_cnt   <= '0;
      pend_last  <= 1'b0;
      pad_first  <= 1'b0;
      rnd        <= '0;
      out_idx    <= '0;
    end else begin
      unique case (state)
        ST_ABSORB: begin
          pad_first <= 1'b1;
          if (wr_en) begin
            fill      <= fill_sum[5:0];
            left_cnt  <= n_left;
            left_data <= rest_data;
            if (!use_left) begin
              bit_length <= bit_length + {58'd0, wr_cnt, 3'b000};
            end
            if (full) begin
              pend_last <= src_last;
              ret_state <= (src_last && n_left == '0) ? ST_PAD : ST_ABSORB;
              rnd       <= '0;
              state     <= ST_RND;
            end else if (src_last) begin
              pend_last <= 1'b0;
              state     <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (!wr_en) begin
            state <= ST_LEN;
          end else begin
            fill      <= fill_sum[5:0];
            pad_first <= 1'b0;
            if (full) begin
              ret_state <= ST_PAD;
              rnd       <= '0;
              state     <= ST_RND;
            end
          end
        end
        ST_LEN: begin
          fill <= fill_sum[5:0];
          if (full) begin
            ret_state <= ST_OUT;
            rnd       <= '0;
            state     <= ST_RND;
          end
        end
        ST_RND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain[0] <= chain[0] + ra;
          chain[1] <= chain[1] + rb;
          chain[2] <= chain[2] + rc;
          chain[3] <= chain[3] + rd;
          out_idx  <= '0;
          state    <= ret_state;
        end
        ST_OUT: begin
          if (dig_ready) begin
            out_idx <= out_idx + 2'd1;
            if (out_idx == 2'd3) begin
              chain[0]   <= INIT_A;
              chain[1]   <= INIT_B;
              chain[2]   <= INIT_C;
              chain[3]   <= INIT_D;
              fill       <= '0;
              bit_length <= '0;
              pend_last  <= 1'b0;
              state      <= ST_ABSORB;
            end
          end
        end
        default: begin
          state <= ST_ABSORB;
        end
      endcase
    end
  end

  // working registers of the compression
  always_ff @(posedge clk) begin
    if (state == ST_RND) begin
      ra <= rd;
      rb <= b_new;
      rc <= rb;
      rd <= rc;
    end else begin
      ra <= chain[0];
      rb <= chain[1];
      rc <= chain[2];
      rd <= chain[3];
    end
    wk <= wk_next;
  end

  // digest words straight from the chaining registers
  assign dig_valid       = (state == ST_OUT);
  assign dig.digest_word = chain[out_idx];
  assign dig.word_index  = out_idx;
  assign dig.digest_last = (out_idx == 2'd3);

`ifndef NO_ASSERTIONS
  a_out_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> fill == '0 && left_cnt == '0)
    else $error("digest shown with bytes still buffered");

  a_len_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_LEN |-> fill == LEN_OFFSET || fill == LEN_HIGH)
    else $error("length field not at its block offset");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_ready && dig.digest_last
      |=> state == ST_ABSORB && bit_length == '0 && chain[0] == INIT_A)
    else $error("no restart after the final digest word");

  a_rnd_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_RND && rnd == 6'd63 |=> state == ST_ADD)
    else $error("compression did not finish after the last round");
`endif

endmodule

### rtl/md5_message_digest_unit.sv
// channel  | role   | handshake            | payload
// msg      | input  | msg_valid/msg_ready  | md5_in_t:  data_word, byte_count, message_end
// dig      | output | dig_valid/dig_ready  | md5_out_t: digest_word, word_index, digest_last
//
// one message word is absorbed per cycle while the core is not busy; each full
// 64-byte block then holds the core for 64 rounds of the single round unit plus the
// chaining add. the final word adds padding and length writes and one or two
// blocks, then four digest transfers.
// reset is synchronous and active high; it restores the initial chaining words.
// a four-entry queue lets the input keep taking words while the core is busy
// or while a digest waits on dig_ready.
module md5_message_digest_unit
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     msg_valid,
  output logic     msg_ready,
  input  md5_in_t  msg,
  output logic     dig_valid,
  input  logic     dig_ready,
  output md5_out_t dig
);

  logic      push_valid;
  logic      push_ready;
  md5_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  md5_item_t pop_item;

  // input stage and byte count clamp
  md5_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_ready  (msg_ready),
    .msg        (msg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  md5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // buffering, padding, compression and digest output
  md5_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .dig_valid  (dig_valid),
    .dig_ready  (dig_ready),
    .dig        (dig)
  );

endmodule

### tb/sv/tb_md5_message_digest_unit.sv
`timescale 1ns / 100ps

module tb_md5_message_digest_unit;
  import md5_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 300;

  // sine-derived additive constants, one per round
  localparam logic [31:0] MIX_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, four per phase
  localparam int SHIFT_BY [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // message lengths in bytes around the padding and block boundaries
  localparam int PAD_EDGES [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 121};

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     msg_valid = 1'b0;
  logic     msg_ready;
  md5_in_t  msg = '0;
  logic     dig_valid;
  logic     dig_ready = 1'b0;
  md5_out_t dig;

  // hash state of the predictor
  logic [31:0] chain_w [4];
  logic [7:0]  blk_bytes [64];
  int unsigned fill_pos;
  logic [63:0] bit_len;
  md5_out_t    pending_digest [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;
  int hold_asked = 0;
  int hold_seen = 0;

  md5_message_digest_unit dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // give up on a hung run
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic logic [31:0] rot_word(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void restart_chain();
    chain_w[0] = 32'h67452301;
    chain_w[1] = 32'hefcdab89;
    chain_w[2] = 32'h98badcfe;
    chain_w[3] = 32'h10325476;
    fill_pos = 0;
    bit_len = '0;
  endfunction

  // 64-round compression of the full buffer into the chaining words
  function automatic void md5_compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++) begin
      m[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
    end
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = a + f + m[g] + MIX_K[i];
      a = d;
      d = c;
      c = b;
      b = b + rot_word(t, SHIFT_BY[(i / 16) * 4 + i % 4]);
    end
    chain_w[0] += a;
    chain_w[1] += b;
    chain_w[2] += c;
    chain_w[3] += d;
  endfunction

  function automatic void append_byte(input logic [7:0] v);
    blk_bytes[fill_pos] = v;
    fill_pos++;
    if (fill_pos == 64) begin
      md5_compress();
      fill_pos = 0;
    end
  endfunction

  // absorb one accepted word; a final word queues the four digest words
  function automatic void absorb_word(input md5_in_t w);
    int n;
    logic [63:0] len;
    md5_out_t r;
    n = (w.byte_count > 3'd4) ? 4 : int'(w.byte_count);
    for (int i = 0; i < n; i++) begin
      append_byte(w.data_word[8*i +: 8]);
      bit_len += 64'd8;
    end
    if (!w.message_end) return;
    len = bit_len;
    append_byte(8'h80);
    while (fill_pos != 56) append_byte(8'h00);
    for (int i = 0; i < 8; i++) append_byte(len[8*i +: 8]);
    for (int k = 0; k < 4; k++) begin
      r.digest_word = chain_w[k];
      r.word_index = 2'(k);
      r.digest_last = (k == 3);
      pending_digest.push_back(r);
    end
    restart_chain();
  endfunction

  // offer one word in bursts with random gaps, predict on transfer
  task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                           input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) msg_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    msg_valid <= 1'b1;
    msg.data_word <= data;
    msg.byte_count <= count;
    msg.message_end <= last;
    do @(posedge clk); while (!msg_ready);
    absorb_word('{data_word: data, byte_count: count, message_end: last});
    words_sent++;
  endtask

  // sender stops and waits for every pending digest word
  task automatic drain_digests();
    @(negedge clk) msg_valid <= 1'b0;
    burst_left = 0;
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  // one complete message of random length and word layout
  task automatic send_random_message();
    int total, left, n;
    logic [2:0] cnt;
    bit ended;
    case ($urandom_range(0, 7))
      0, 1:    total = PAD_EDGES[$urandom_range(0, 8)];
      2:       total = $urandom_range(100, 260);
      default: total = $urandom_range(0, 80);
    endcase
    left = total;
    ended = 1'b0;
    while (left > 0) begin
      n = (left >= 4 && $urandom_range(0, 3) != 0) ? 4 : $urandom_range(1, (left < 4) ? left : 4);
      cnt = 3'(n);
      // oversized counts behave as four bytes
      if (n == 4 && $urandom_range(0, 7) == 0) cnt = 3'($urandom_range(5, 7));
      left -= n;
      ended = (left == 0) && ($urandom_range(0, 4) != 0);
      send_word($urandom, cnt, ended);
      // stray empty word in the middle of a message
      if (left > 0 && $urandom_range(0, 15) == 0) send_word($urandom, 3'd0, 1'b0);
    end
    // empty final word closes the message
    if (!ended) send_word($urandom, 3'd0, 1'b1);
  endtask

  task automatic test_empty_message();
    send_word(32'hffffffff, 3'd0, 1'b1);
  endtask

  // bytes above the count must be ignored
  task automatic test_partial_word();
    send_word(32'ha5636261, 3'd3, 1'b1);
  endtask

  task automatic test_count_extremes();
    send_word($urandom, 3'd5, 1'b0);
    send_word(32'hffffffff, 3'd0, 1'b0);
    send_word($urandom, 3'd6, 1'b0);
    send_word($urandom, 3'd7, 1'b1);
  endtask

  task automatic test_data_extremes();
    send_word(32'h00000000, 3'd4, 1'b0);
    send_word(32'hffffffff, 3'd4, 1'b1);
  endtask

  // 56 bytes leave no room for the length, so padding spills into a second block
  task automatic test_pad_spill();
    for (int i = 0; i < 14; i++) send_word($urandom, 3'd4, i == 13);
  endtask

  task automatic test_random_messages(input int n_words, input bit steady);
    int target;
    target = words_sent + n_words;
    sender_steady = steady;
    while (words_sent < target) send_random_message();
    sender_steady = 1'b0;
  endtask

  // long receiver hold-off while short messages keep coming
  task automatic test_output_backpressure();
    hold_asked++;
    sender_steady = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_word($urandom, 3'($urandom_range(1, 4)), 1'b0);
      send_word($urandom, 3'($urandom_range(0, 4)), 1'b1);
    end
    sender_steady = 1'b0;
  endtask

  // receiver stalls on a changing pattern, with occasional long hold-offs
  initial begin : digest_sink
    int mode, mode_left, hold_left, tick;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        dig_ready <= 1'b0;
      end else begin
        case (mode)
          0:       dig_ready <= 1'b1;
          1:       dig_ready <= 1'($urandom_range(0, 1));
          2:       dig_ready <= (tick % 4 == 0);
          default: dig_ready <= (tick % 7 >= 2);
        endcase
      end
    end
  end

  // compare each digest transfer with the oldest prediction
  always @(posedge clk) begin : check_digest
    md5_out_t want;
    if (!rst && dig_valid && dig_ready) begin
      if (pending_digest.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d",
                                  dig.digest_word, dig.word_index));
      end else begin
        want = pending_digest.pop_front();
        if (dig.digest_word !== want.digest_word) begin
          report_mismatch($sformatf("digest_word %h, wanted %h (index %0d)",
                                    dig.digest_word, want.digest_word, want.word_index));
        end
        if (dig.word_index !== want.word_index) begin
          report_mismatch($sformatf("word_index %0d, wanted %0d",
                                    dig.word_index, want.word_index));
        end
        if (dig.digest_last !== want.digest_last) begin
          report_mismatch($sformatf("digest_last %b, wanted %b (index %0d)",
                                    dig.digest_last, want.digest_last, want.word_index));
        end
      end
    end
  end

  initial begin
    restart_chain();
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_empty_message();
    test_partial_word();
    test_count_extremes();
    test_data_extremes();
    test_pad_spill();
    drain_digests();

    test_random_messages(200, 1'b0);
    test_output_backpressure();
    drain_digests();
    test_random_messages(80, 1'b1);
    test_random_messages(170, 1'b0);
    drain_digests();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/md5_pkg.sv
rtl/md5_front.sv
rtl/md5_queue.sv
rtl/md5_core.sv
rtl/md5_message_digest_unit.sv
tb/sv/tb_md5_message_digest_unit.sv
